### rtl/bssa_pkg.sv
// Shared types and constants for the bitmap slab slot allocator.
// Used by the classifier, request queue, allocator back end and top level.
package bssa_pkg;

  localparam int NUM_FRAMES  = 64;
  localparam int FRAME_W     = 6;
  localparam int MAX_SLOTS   = 64;
  localparam int SLOT_W      = 6;
  localparam int NUM_CLASSES = 4;
  localparam int CLASS_W     = 2;
  localparam int CLS_IN_W    = 3;
  localparam int SIZE_W      = 13;
  localparam int CNT_W       = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;

  localparam logic [SIZE_W-1:0] SIZE_CAP = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS3 = 3'd7;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_NO_FRAME     = 3'd2,
    ST_BAD_CLASS    = 3'd3,
    ST_SLAB_UNUSED  = 3'd4,
    ST_SLOT_RANGE   = 3'd5,
    ST_ALREADY_FREE = 3'd6,
    ST_MISMATCH     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    K_ALLOC     = 2'd0,
    K_FREE      = 2'd1,
    K_TOO_LARGE = 2'd2,
    K_BAD_CLASS = 2'd3
  } kind_t;

  localparam logic CMD_ALLOC = 1'b0;

  typedef struct packed {
    kind_t               kind;
    logic [CLASS_W-1:0]  cls;
    logic [FRAME_W-1:0]  slab;
    logic [SLOT_W-1:0]   slot;
  } req_t;

  typedef struct packed {
    logic [CLASS_W-1:0]  cls;
    logic [SLOT_W-1:0]   slot;
    logic [FRAME_W-1:0]  slab;
    status_t             status;
    logic                ok;
  } result_t;

endpackage

### rtl/bssa_front.sv
// Request classifier: maps an allocate size to its class, flags oversize requests and screens bad classes.
// Depends on bssa_pkg.
module bssa_front (
  input  logic                                            command,
  input  logic [bssa_pkg::SIZE_W-1:0]                     request_size,
  input  logic [bssa_pkg::FRAME_W-1:0]                    slab_index,
  input  logic [bssa_pkg::SLOT_W-1:0]                     obj_slot,
  input  logic [bssa_pkg::CLS_IN_W-1:0]                   class_index,
  input  logic [bssa_pkg::NUM_CLASSES-1:0][bssa_pkg::SIZE_W-1:0] class_limit,
  output bssa_pkg::req_t                                  req
);
  import bssa_pkg::*;

  logic               hit;
  logic [CLASS_W-1:0] hit_cls;

  // first class whose limit covers the size
  always_comb begin
    hit     = 1'b0;
    hit_cls = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (request_size <= class_limit[i]) begin
        hit     = 1'b1;
        hit_cls = CLASS_W'(i);
      end
    end
  end

  always_comb begin
    req.slab = slab_index;
    req.slot = obj_slot;
    if (command == CMD_ALLOC) begin
      req.cls = hit_cls;
      if (request_size > SIZE_CAP || !hit) begin
        req.kind = K_TOO_LARGE;
      end else begin
        req.kind = K_ALLOC;
      end
    end else begin
      req.cls = class_index[CLASS_W-1:0];
      if ({1'b0, class_index} >= (CLS_IN_W+1)'(NUM_CLASSES)) begin
        req.kind = K_BAD_CLASS;
      end else begin
        req.kind = K_FREE;
      end
    end
  end

endmodule

### rtl/bssa_queue.sv
// Short request queue between the classifier and the allocator back end.
// Depends on bssa_pkg.
module bssa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  bssa_pkg::req_t push_req,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bssa_pkg::req_t pop_req
);
  import bssa_pkg::*;

  req_t                entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_req    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/bssa_back.sv
// Allocator back end: frame tables, slot bitmaps, per-class partial lists.
// Depends on bssa_pkg.
module bssa_back (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             req_valid,
  output logic                                             req_ready,
  input  bssa_pkg::req_t                                   req,
  input  logic [bssa_pkg::NUM_CLASSES-1:0][bssa_pkg::CNT_W-1:0] class_slots,
  output logic                                             res_valid,
  input  logic                                             res_ready,
  output bssa_pkg::result_t                                res
);
  import bssa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EX} state_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [CNT_W-1:0]   cap;
    logic [CNT_W-1:0]   freec;
    logic               full;
  } meta_t;

  state_t state;
  req_t   work;

  logic [NUM_FRAMES-1:0]                  in_use;
  logic [FRAME_W:0]                       next_frame;
  logic [NUM_CLASSES-1:0]                 cur_valid;
  logic [NUM_CLASSES-1:0][FRAME_W-1:0]    cur_slab;
  logic [NUM_CLASSES-1:0]                 qv;
  logic [NUM_CLASSES-1:0][FRAME_W-1:0]    head;
  logic [NUM_CLASSES-1:0][FRAME_W-1:0]    tail;

  // frame memories
  logic [MAX_SLOTS-1:0] bm_mem  [NUM_FRAMES];
  meta_t                meta_mem[NUM_FRAMES];
  logic [FRAME_W-1:0]   nxt_mem [NUM_FRAMES];
  logic [FRAME_W-1:0]   prv_mem [NUM_FRAMES];
  logic [MAX_SLOTS-1:0] bm_q;
  meta_t                meta_q;
  logic [FRAME_W-1:0]   nxt_q;
  logic [FRAME_W-1:0]   prv_q;

  logic                 bm_we;
  logic [FRAME_W-1:0]   bm_wa;
  logic [MAX_SLOTS-1:0] bm_wd;
  logic                 meta_we;
  logic [FRAME_W-1:0]   meta_wa;
  meta_t                meta_wd;
  logic                 nxt_we;
  logic [FRAME_W-1:0]   nxt_wa;
  logic [FRAME_W-1:0]   nxt_wd;
  logic                 prv_we;
  logic [FRAME_W-1:0]   prv_wa;
  logic [FRAME_W-1:0]   prv_wd;

  logic                 out_free;
  logic                 take;
  logic [CLASS_W-1:0]   c_in;
  logic [CLASS_W-1:0]   c_w;
  logic [CNT_W-1:0]     slots_raw;
  logic [CNT_W-1:0]     cap_new;
  logic [FRAME_W-1:0]   new_frame;
  logic                 claim;
  logic                 adopt;
  logic                 go_rd;
  logic [FRAME_W-1:0]   slab_sel;
  logic [MAX_SLOTS-1:0] cap_mask;
  logic [MAX_SLOTS-1:0] freebits;
  logic [SLOT_W-1:0]    found_slot;
  logic [CNT_W-1:0]     freec_dec;
  logic                 ex_alloc;
  logic                 ex_rm;
  logic                 ex_free;
  logic                 ex_push;
  logic                 emit;
  result_t              emit_res;

  assign out_free  = !res_valid || res_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign take      = req_valid && req_ready;
  assign c_in      = req.cls;
  assign c_w       = work.cls;
  assign slots_raw = class_slots[c_in];
  assign new_frame = next_frame[FRAME_W-1:0];

  always_comb begin
    if (slots_raw == '0) begin
      cap_new = CNT_W'(1);
    end else if (slots_raw > CNT_W'(MAX_SLOTS)) begin
      cap_new = CNT_W'(MAX_SLOTS);
    end else begin
      cap_new = slots_raw;
    end
  end

  always_comb begin
    if (meta_q.cap >= CNT_W'(MAX_SLOTS)) begin
      cap_mask = '1;
    end else begin
      cap_mask = (MAX_SLOTS'(1) << meta_q.cap[SLOT_W-1:0]) - MAX_SLOTS'(1);
    end
    freebits = ~bm_q & cap_mask;
    found_slot = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (freebits[i]) found_slot = SLOT_W'(i);
    end
    freec_dec = (meta_q.freec != '0) ? meta_q.freec - 1'b1 : '0;
  end

  // dispatch and execute decisions
  always_comb begin
    claim    = 1'b0;
    adopt    = 1'b0;
    go_rd    = 1'b0;
    slab_sel = req.slab;
    ex_alloc = 1'b0;
    ex_rm    = 1'b0;
    ex_free  = 1'b0;
    ex_push  = 1'b0;
    emit     = 1'b0;
    emit_res = '{cls: '0, slot: '0, slab: '0, status: ST_OK, ok: 1'b1};
    if (take) begin
      case (req.kind)
        K_TOO_LARGE: begin
          emit = 1'b1;
          emit_res.status = ST_TOO_LARGE;
        end
        K_BAD_CLASS: begin
          emit = 1'b1;
          emit_res.status = ST_BAD_CLASS;
        end
        K_FREE: begin
          if (!in_use[req.slab]) begin
            emit = 1'b1;
            emit_res.status = ST_SLAB_UNUSED;
          end else begin
            go_rd = 1'b1;
          end
        end
        K_ALLOC: begin
          if (cur_valid[c_in]) begin
            go_rd    = 1'b1;
            slab_sel = cur_slab[c_in];
          end else if (qv[c_in]) begin
            adopt    = 1'b1;
            go_rd    = 1'b1;
            slab_sel = head[c_in];
          end else if (next_frame[FRAME_W]) begin
            emit = 1'b1;
            emit_res.status = ST_NO_FRAME;
          end else begin
            claim    = 1'b1;
            go_rd    = 1'b1;
            slab_sel = new_frame;
          end
        end
        default: begin
          emit = 1'b1;
          emit_res.status = ST_BAD_CLASS;
        end
      endcase
    end else if (state == S_EX) begin
      emit = 1'b1;
      if (work.kind == K_ALLOC) begin
        if (freebits == '0) begin
          emit_res.status = ST_NO_FRAME;
        end else begin
          ex_alloc      = 1'b1;
          ex_rm         = (freec_dec == '0);
          emit_res.slab = work.slab;
          emit_res.slot = found_slot;
          emit_res.cls  = c_w;
        end
      end else begin
        if (meta_q.cls != c_w) begin
          emit_res.status = ST_MISMATCH;
        end else if ({1'b0, work.slot} >= meta_q.cap) begin
          emit_res.status = ST_SLOT_RANGE;
        end else if (!bm_q[work.slot]) begin
          emit_res.status = ST_ALREADY_FREE;
        end else begin
          ex_free = 1'b1;
          ex_push = meta_q.full;
        end
      end
    end
    if (emit_res.status != ST_OK) emit_res.ok = 1'b0;
  end

  // memory write ports
  always_comb begin
    bm_we   = 1'b0;
    bm_wa   = work.slab;
    bm_wd   = bm_q;
    meta_we = 1'b0;
    meta_wa = work.slab;
    meta_wd = meta_q;
    nxt_we  = 1'b0;
    nxt_wa  = prv_q;
    nxt_wd  = nxt_q;
    prv_we  = 1'b0;
    prv_wa  = nxt_q;
    prv_wd  = prv_q;
    if (claim) begin
      bm_we   = 1'b1;
      bm_wa   = new_frame;
      bm_wd   = '0;
      meta_we = 1'b1;
      meta_wa = new_frame;
      meta_wd = '{cls: c_in, cap: cap_new, freec: cap_new, full: 1'b0};
    end else if (ex_alloc) begin
      bm_we         = 1'b1;
      bm_wd         = bm_q | (MAX_SLOTS'(1) << found_slot);
      meta_we       = 1'b1;
      meta_wd.freec = freec_dec;
      meta_wd.full  = meta_q.full | ex_rm;
      // unlink from the partial list
      if (ex_rm) begin
        nxt_we = (work.slab != head[c_w]);
        prv_we = (work.slab != tail[c_w]);
      end
    end else if (ex_free) begin
      bm_we   = 1'b1;
      bm_wd   = bm_q & ~(MAX_SLOTS'(1) << work.slot);
      meta_we = 1'b1;
      if (meta_q.freec < meta_q.cap) meta_wd.freec = meta_q.freec + 1'b1;
      meta_wd.full = 1'b0;
      // append to the partial list tail
      if (ex_push && qv[c_w]) begin
        nxt_we = 1'b1;
        nxt_wa = tail[c_w];
        nxt_wd = work.slab;
        prv_we = 1'b1;
        prv_wa = work.slab;
        prv_wd = tail[c_w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we)   bm_mem[bm_wa]     <= bm_wd;
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (nxt_we)  nxt_mem[nxt_wa]   <= nxt_wd;
    if (prv_we)  prv_mem[prv_wa]   <= prv_wd;
    bm_q   <= bm_mem[work.slab];
    meta_q <= meta_mem[work.slab];
    nxt_q  <= nxt_mem[work.slab];
    prv_q  <= prv_mem[work.slab];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_use     <= '0;
      next_frame <= '0;
      cur_valid  <= '0;
      qv         <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
        res       <= emit_res;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            work.kind <= req.kind;
            work.cls  <= req.cls;
            work.slot <= req.slot;
            work.slab <= slab_sel;
            if (go_rd) state <= S_RD;
            if (adopt) begin
              cur_valid[c_in] <= 1'b1;
              cur_slab[c_in]  <= head[c_in];
            end
            if (claim) begin
              in_use[new_frame] <= 1'b1;
              next_frame        <= next_frame + 1'b1;
              qv[c_in]          <= 1'b1;
              head[c_in]        <= new_frame;
              tail[c_in]        <= new_frame;
              cur_valid[c_in]   <= 1'b1;
              cur_slab[c_in]    <= new_frame;
            end
          end
        end
        S_RD: begin
          state <= S_EX;
        end
        S_EX: begin
          state <= S_IDLE;
          if (ex_rm) begin
            cur_valid[c_w] <= 1'b0;
            if (work.slab == head[c_w] && work.slab == tail[c_w]) begin
              qv[c_w] <= 1'b0;
            end else if (work.slab == head[c_w]) begin
              head[c_w] <= nxt_q;
            end else if (work.slab == tail[c_w]) begin
              tail[c_w] <= prv_q;
            end
          end
          if (ex_push) begin
            tail[c_w] <= work.slab;
            if (!qv[c_w]) begin
              qv[c_w]   <= 1'b1;
              head[c_w] <= work.slab;
            end
            if (!cur_valid[c_w]) begin
              cur_valid[c_w] <= 1'b1;
              cur_slab[c_w]  <= work.slab;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/bitmap_slab_slot_allocator_core.sv
// Slab slot allocator core: holds the class registers, ties classifier,
// request queue and allocator back end together. Depends on bssa_pkg.
//
// Allocate and free requests enter through a four-deep queue and are carried
// out one at a time. A request that reads a frame (every allocate that finds
// or claims a slab, every free of a claimed frame of a valid class) goes through
// dispatch, registered frame memory read, then update and result in the back
// end; one that fails on its fields alone gets its result at dispatch. Input
// requests keep entering while a result waits on the output register. The
// user must write class registers only while no request is in flight; the
// block does not enforce it. No clearing pass after reset.
module bitmap_slab_slot_allocator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [12:0] request_size, [18:13] slab_index, [24:19] obj_slot,
  // [27:25] class_index, [31:28] zero
  input  logic [31:0]                       s_axis_tdata,
  // [0] command
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] ok, [3:1] status, [9:4] granted_slab, [15:10] granted_slot,
  // [17:16] granted_class, [23:18] zero
  output logic [23:0]                       m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [bssa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bssa_pkg::SIZE_W-1:0]       cfg_data
);
  import bssa_pkg::*;

  logic [NUM_CLASSES-1:0][SIZE_W-1:0] class_limit;
  logic [NUM_CLASSES-1:0][CNT_W-1:0]  class_slots;
  req_t                               front_req;
  req_t                               back_req;
  logic                               back_valid;
  logic                               back_ready;
  result_t                            res;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_limit[0] <= 13'd64;
      class_limit[1] <= 13'd128;
      class_limit[2] <= 13'd256;
      class_limit[3] <= 13'd512;
      class_slots[0] <= 7'd62;
      class_slots[1] <= 7'd31;
      class_slots[2] <= 7'd15;
      class_slots[3] <= 7'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIMIT0: class_limit[0] <= cfg_data;
        REG_LIMIT1: class_limit[1] <= cfg_data;
        REG_LIMIT2: class_limit[2] <= cfg_data;
        REG_LIMIT3: class_limit[3] <= cfg_data;
        REG_SLOTS0: class_slots[0] <= cfg_data[CNT_W-1:0];
        REG_SLOTS1: class_slots[1] <= cfg_data[CNT_W-1:0];
        REG_SLOTS2: class_slots[2] <= cfg_data[CNT_W-1:0];
        REG_SLOTS3: class_slots[3] <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  bssa_front u_front (
    .command      (s_axis_tuser),
    .request_size (s_axis_tdata[12:0]),
    .slab_index   (s_axis_tdata[18:13]),
    .obj_slot     (s_axis_tdata[24:19]),
    .class_index  (s_axis_tdata[27:25]),
    .class_limit  (class_limit),
    .req          (front_req)
  );

  bssa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_axis_tvalid),
    .push_ready (s_axis_tready),
    .push_req   (front_req),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_req    (back_req)
  );

  bssa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (back_valid),
    .req_ready   (back_ready),
    .req         (back_req),
    .class_slots (class_slots),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res         (res)
  );

  assign m_axis_tdata = {6'd0, res};

`ifndef SYNTH
  a_ok_matches_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.ok == (res.status == ST_OK)))
    else $error("ok flag disagrees with status");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !res.ok) |-> (res.slab == '0 && res.slot == '0 && res.cls == '0))
    else $error("failed request carries a grant");

  a_no_dispatch_while_held: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !back_ready)
    else $error("back end dispatched while result held");
`endif

endmodule

### dv/bitmap_slab_slot_allocator_core_tb.sv
// Self-checking testbench for bitmap_slab_slot_allocator_core.
// Streams allocate and free requests, predicts every result in a local
// allocator model and compares it field by field. Depends on bssa_pkg.
`timescale 1ns / 1ps

module bitmap_slab_slot_allocator_core_tb;
  import bssa_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [12:0] size;
    logic [5:0]  slab;
    logic [5:0]  slot;
    logic [2:0]  cls;
  } request_t;

  typedef struct packed {
    logic        ok;
    status_t     status;
    logic [5:0]  slab;
    logic [5:0]  slot;
    logic [1:0]  cls;
  } grant_t;

  typedef struct packed {
    logic [5:0] slab;
    logic [5:0] slot;
    logic [1:0] cls;
  } handle_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  bitmap_slab_slot_allocator_core uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // allocator state mirror
  logic [12:0] class_limit [4];
  logic [6:0]  class_slots [4];
  logic [63:0] slot_map [64];
  logic [6:0]  free_cnt [64];
  logic [6:0]  frame_cap [64];
  logic [1:0]  frame_cls [64];
  logic        frame_used [64];
  logic        frame_full [64];
  logic [5:0]  partial_q [4][64];
  int          partial_n [4];
  logic        cur_valid [4];
  logic [5:0]  cur_slab [4];

  request_t pending_reqs [$];
  grant_t   expected_grants [$];
  handle_t  live_handles [$];

  request_t cur_req;
  logic     req_fire, grant_fire;
  int       req_wait, grant_wait;
  bit       burst_mode;
  int       n_queued, n_accepted, n_errors;
  int       n_alloc_ok, n_free_ok, n_rejected;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    if (burst_mode) return 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic predict_alloc(input logic [12:0] size, output grant_t g);
    int c, i, slot;
    logic [6:0] cap;
    logic [5:0] f;
    logic [63:0] avail;
    g = '0;
    g.status = ST_TOO_LARGE;
    if (size > SIZE_CAP) return;
    for (c = 0; c < 4; c++) if (size <= class_limit[c]) break;
    if (c >= 4) return;
    if (!cur_valid[c]) begin
      if (partial_n[c] > 0) begin
        f = partial_q[c][0];
      end else begin
        for (i = 0; i < 64; i++) if (!frame_used[i]) break;
        if (i >= 64) begin
          g.status = ST_NO_FRAME;
          return;
        end
        cap = class_slots[c];
        if (cap < 1) cap = 1;
        if (cap > 64) cap = 64;
        f = i[5:0];
        frame_used[f] = 1; frame_cls[f] = c[1:0]; frame_full[f] = 0;
        frame_cap[f] = cap; free_cnt[f] = cap; slot_map[f] = '0;
        partial_q[c][partial_n[c]] = f;
        partial_n[c]++;
      end
      cur_valid[c] = 1;
      cur_slab[c] = f;
    end
    f = cur_slab[c];
    avail = ~slot_map[f] & ((frame_cap[f] >= 64) ? '1 : ((64'd1 << frame_cap[f]) - 1));
    slot = 0;
    while (!avail[slot]) slot++;
    slot_map[f][slot] = 1'b1;
    if (free_cnt[f] > 0) free_cnt[f]--;
    if (free_cnt[f] == 0) begin
      frame_full[f] = 1;
      for (i = 0; i < partial_n[c]; i++) if (partial_q[c][i] == f) break;
      if (i < partial_n[c]) begin
        for (; i + 1 < partial_n[c]; i++) partial_q[c][i] = partial_q[c][i+1];
        partial_n[c]--;
      end
      cur_valid[c] = 0;
    end
    g.ok = 1; g.status = ST_OK; g.slab = f; g.slot = slot[5:0]; g.cls = c[1:0];
    live_handles.push_back('{f, slot[5:0], c[1:0]});
  endtask

  task automatic predict_free(input request_t r, output grant_t g);
    int i;
    g = '0;
    if (r.cls >= NUM_CLASSES) g.status = ST_BAD_CLASS;
    else if (!frame_used[r.slab]) g.status = ST_SLAB_UNUSED;
    else if (frame_cls[r.slab] != r.cls[1:0]) g.status = ST_MISMATCH;
    else if (r.slot >= frame_cap[r.slab]) g.status = ST_SLOT_RANGE;
    else if (!slot_map[r.slab][r.slot]) g.status = ST_ALREADY_FREE;
    else begin
      g.ok = 1; g.status = ST_OK;
      slot_map[r.slab][r.slot] = 1'b0;
      if (free_cnt[r.slab] < frame_cap[r.slab]) free_cnt[r.slab]++;
      if (frame_full[r.slab]) begin
        frame_full[r.slab] = 0;
        partial_q[r.cls][partial_n[r.cls]] = r.slab;
        partial_n[r.cls]++;
        if (!cur_valid[r.cls]) begin
          cur_valid[r.cls] = 1;
          cur_slab[r.cls] = r.slab;
        end
      end
      for (i = 0; i < live_handles.size(); i++)
        if (live_handles[i] == handle_t'{r.slab, r.slot, r.cls[1:0]}) begin
          live_handles.delete(i);
          break;
        end
    end
  endtask

  // predict on each accepted request, then check each delivered result
  always @(posedge clk) begin
    grant_t g, got;
    req_fire   <= s_axis_tvalid && s_axis_tready;
    grant_fire <= m_axis_tvalid && m_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      if (cur_req.cmd == CMD_ALLOC) predict_alloc(cur_req.size, g);
      else predict_free(cur_req, g);
      if (g.ok && cur_req.cmd == CMD_ALLOC) n_alloc_ok++;
      else if (g.ok) n_free_ok++;
      else n_rejected++;
      expected_grants.push_back(g);
      n_accepted++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[0], status_t'(m_axis_tdata[3:1]), m_axis_tdata[9:4],
              m_axis_tdata[15:10], m_axis_tdata[17:16]};
      if (expected_grants.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        n_errors++;
      end else begin
        g = expected_grants.pop_front();
        if (got.ok !== g.ok) begin
          $error("ok: expected %0d got %0d", g.ok, got.ok); n_errors++;
        end
        if (got.status !== g.status) begin
          $error("status: expected %0d got %0d", g.status, got.status); n_errors++;
        end
        if (got.slab !== g.slab) begin
          $error("granted_slab: expected %0d got %0d", g.slab, got.slab); n_errors++;
        end
        if (got.slot !== g.slot) begin
          $error("granted_slot: expected %0d got %0d", g.slot, got.slot); n_errors++;
        end
        if (got.cls !== g.cls) begin
          $error("granted_class: expected %0d got %0d", g.cls, got.cls); n_errors++;
        end
      end
    end
  end

  // request driver: hold until taken, then idle a drawn number of cycles
  always @(negedge clk) begin
    request_t r;
    if (rst) begin
      s_axis_tvalid <= 0;
      req_wait <= 0;
    end else if (!(s_axis_tvalid && !req_fire)) begin
      if (req_wait > 0) begin
        req_wait <= req_wait - 1;
        s_axis_tvalid <= 0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        cur_req <= r;
        s_axis_tdata <= {4'b0, r.cls, r.slot, r.slab, r.size};
        s_axis_tuser <= r.cmd;
        s_axis_tvalid <= 1;
        req_wait <= draw_wait();
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // result sink stalls
  always @(negedge clk) begin
    int w;
    w = grant_wait;
    if (rst) begin
      m_axis_tready <= 0;
      grant_wait <= 0;
    end else begin
      if (grant_fire) w = draw_wait();
      if (w > 0) begin
        m_axis_tready <= 0;
        grant_wait <= w - 1;
      end else begin
        m_axis_tready <= 1;
        grant_wait <= 0;
      end
    end
  end

  task automatic push_req(input logic cmd, input int size, input int slab,
                          input int slot, input int cls);
    pending_reqs.push_back('{cmd, size[12:0], slab[5:0], slot[5:0], cls[2:0]});
    n_queued++;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || n_accepted != n_queued ||
           expected_grants.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val[12:0];
    if (idx < REG_SLOTS0) class_limit[idx] = val[12:0];
    else class_slots[idx - REG_SLOTS0] = val[6:0];
  endtask

  task automatic set_classes(input int l0, l1, l2, l3, s0, s1, s2, s3);
    drain();
    write_reg(REG_LIMIT0, l0); write_reg(REG_LIMIT1, l1);
    write_reg(REG_LIMIT2, l2); write_reg(REG_LIMIT3, l3);
    write_reg(REG_SLOTS0, s0); write_reg(REG_SLOTS1, s1);
    write_reg(REG_SLOTS2, s2); write_reg(REG_SLOTS3, s3);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_reqs(input int count);
    int k, r, c, sel;
    handle_t h;
    for (k = 0; k < count; k++) begin
      while (pending_reqs.size() > 1) @(posedge clk);
      if (k % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (live_handles.size() > 120 && r < 60) r = 0;
      if (live_handles.size() > 0 && r < 45) begin
        sel = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[sel];
        push_req(1, $urandom_range(0, 8191), h.slab, h.slot, h.cls);
      end else if (r < 88) begin
        c = $urandom_range(0, 3);
        sel = $urandom_range(0, 9);
        if (sel < 8)
          push_req(0, $urandom_range(0, (class_limit[c] > 4096) ? 4096 : class_limit[c]),
                   $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 7));
        else
          push_req(0, $urandom_range(0, sel == 8 ? 4200 : 8191), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 7));
      end else begin
        // broken handle: random fields, sometimes near a live one
        if (live_handles.size() > 0 && r < 94) begin
          h = live_handles[$urandom_range(0, live_handles.size() - 1)];
          push_req(1, 0, h.slab, $urandom_range(0, 63), $urandom_range(0, 4) == 0 ?
                   $urandom_range(0, 7) : h.cls);
        end else
          push_req(1, $urandom_range(0, 8191), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 7));
      end
    end
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = 0;
    m_axis_tready = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    req_fire = 0; grant_fire = 0; req_wait = 0; grant_wait = 0;
    burst_mode = 0;
    n_queued = 0; n_accepted = 0; n_errors = 0;
    n_alloc_ok = 0; n_free_ok = 0; n_rejected = 0;
    class_limit = '{64, 128, 256, 512};
    class_slots = '{62, 31, 15, 7};
    for (int i = 0; i < 64; i++) frame_used[i] = 0;
    partial_n = '{0, 0, 0, 0};
    cur_valid = '{0, 0, 0, 0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: class edges, oversize, every free rejection, free and reuse
    push_req(0, 0, 0, 0, 0);
    push_req(0, 1, 0, 0, 0);
    push_req(0, 64, 0, 0, 0);
    push_req(0, 65, 0, 0, 0);
    push_req(0, 128, 0, 0, 0);
    push_req(0, 256, 0, 0, 0);
    push_req(0, 512, 0, 0, 0);
    push_req(0, 513, 0, 0, 0);
    push_req(0, 4096, 0, 0, 0);
    push_req(0, 8191, 63, 63, 7);
    push_req(1, 0, 0, 0, 4);
    push_req(1, 0, 0, 0, 7);
    push_req(1, 0, 63, 0, 0);
    push_req(1, 0, 0, 0, 1);
    push_req(1, 0, 0, 63, 0);
    push_req(1, 0, 0, 5, 0);
    push_req(1, 0, 0, 1, 0);
    push_req(1, 0, 0, 1, 0);
    push_req(0, 10, 0, 0, 0);
    // limits at the extremes; slot counts of zero, one, max and beyond
    set_classes(4096, 1, 8191, 0, 0, 1, 64, 127);
    push_req(0, 4096, 0, 0, 0);
    push_req(0, 4096, 0, 0, 0);
    push_req(0, 1, 0, 0, 0);
    push_req(1, 0, 1, 0, 0);
    push_req(0, 4097, 0, 0, 0);

    random_reqs(250);
    set_classes(32, 100, 300, 4096, 2, 3, 5, 8);
    random_reqs(300);
    set_classes($urandom_range(1, 200), $urandom_range(200, 1000),
                $urandom_range(1000, 3000), $urandom_range(3000, 4096),
                $urandom_range(1, 64), $urandom_range(1, 64),
                $urandom_range(1, 64), $urandom_range(0, 127));
    random_reqs(250);
    set_classes(64, 128, 256, 512, 62, 31, 15, 7);
    random_reqs(230);
    drain();

    $display("ran %0d requests: %0d allocations and %0d frees granted, %0d rejected",
             n_accepted, n_alloc_ok, n_free_ok, n_rejected);
    $display("%0d live objects left, %0d mismatching fields", live_handles.size(), n_errors);
    if (n_errors == 0) $display("bitmap_slab_slot_allocator_core_tb: PASS");
    else $display("bitmap_slab_slot_allocator_core_tb: FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("bitmap_slab_slot_allocator_core_tb: FAIL");
    $finish;
  end

endmodule

### files.f
rtl/bssa_pkg.sv
rtl/bssa_front.sv
rtl/bssa_queue.sv
rtl/bssa_back.sv
rtl/bitmap_slab_slot_allocator_core.sv
dv/bitmap_slab_slot_allocator_core_tb.sv
